[sv/rcpf_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register codes and the sine table builder for the program fade.
package rcpf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FRAME_W  = 31;
	localparam int FADE_W   = 20;
	localparam int CFG_W    = 31;

	localparam int GAIN_TABLE_BITS_DEF = 10;
	localparam int GAIN_FRAC_BITS_DEF  = 16;

	localparam logic [FRAME_W-1:0] TOTAL_RESET = '0;
	localparam logic [FADE_W-1:0]  FADE_RESET  = 20'd88200;

	// Q30 constants for the sine series
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	typedef enum logic [0:0] {
		REG_TOTAL = 1'b0,
		REG_FADE  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
		logic [FRAME_W-1:0]         frame_index;
		logic                       last_frame;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic                       last_out;
	} out_item_t;

	// Samples and decisions that ride alongside the gain computation
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       last;
		logic                       pass;
		logic                       zero;
	} side_t;

	// Divide by the series denominators, innermost term first
	function automatic logic [63:0] series_div(input logic [63:0] p, input int i);
		logic [63:0] q;
		case (i)
			0: q = p / 64'd156;
			1: q = p / 64'd110;
			2: q = p / 64'd72;
			3: q = p / 64'd42;
			4: q = p / 64'd20;
			default: q = p / 64'd6;
		endcase
		return q;
	endfunction

	// Quarter-wave sine entry j of a table with 2^(tb-1) steps, rounded to q fraction bits
	function automatic logic [63:0] sine_entry(input int j, input int tb, input int q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		x  = (PI_HALF_Q30 * 64'(j)) >> (tb - 1);
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			t = Q30_ONE - series_div((x2 * t) >> 30, i);
		end
		v = (x * t) >> 30;
		return (v + (64'd1 << (29 - q))) >> (30 - q);
	endfunction

endpackage

[sv/rcpf_front.sv]
`timescale 1ns / 1ps
// Front stages: distance to the nearer program edge and the pass / silence decisions.
module rcpf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rcpf_pkg::in_item_t             in_item,
	input  logic [rcpf_pkg::FRAME_W-1:0]   total_frames,
	input  logic [rcpf_pkg::FADE_W-1:0]    fade_frames,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rcpf_pkg::side_t                out_side,
	output logic [rcpf_pkg::FADE_W-1:0]    out_m
);
	import rcpf_pkg::*;

	logic                      v_s1;
	logic                      v_s2;
	logic                      en_s1;
	logic                      en_s2;
	side_t                     side_s1;
	side_t                     side_s2;
	logic [FRAME_W-1:0]        pos_s1;
	logic signed [FRAME_W:0]   tail_s1;
	logic [FADE_W-1:0]         m_s2;
	logic signed [FRAME_W:0]   pos_sgn;
	logic signed [FRAME_W:0]   m;
	logic                      pass;
	logic                      zero;

	// Stall a stage only when it is full and the next one cannot take its item
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Take the nearer edge and decide pass-through or silence
	always_comb begin
		pos_sgn = $signed({1'b0, pos_s1});
		m       = (pos_sgn < tail_s1) ? pos_sgn : tail_s1;
		pass    = (total_frames == '0) ||
			(m >= $signed({{(FRAME_W - FADE_W + 1){1'b0}}, fade_frames}));
		zero    = m[FRAME_W] || (m == '0);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1.left  <= in_item.left_in;
			side_s1.right <= in_item.right_in;
			side_s1.last  <= in_item.last_frame;
			side_s1.pass  <= 1'b0;
			side_s1.zero  <= 1'b0;
			pos_s1        <= in_item.frame_index;
			tail_s1       <= $signed({1'b0, total_frames}) - $signed({1'b0, in_item.frame_index});
		end
		if (en_s2) begin
			side_s2.left  <= side_s1.left;
			side_s2.right <= side_s1.right;
			side_s2.last  <= side_s1.last;
			side_s2.pass  <= pass;
			side_s2.zero  <= zero;
			m_s2          <= m[FADE_W-1:0];
		end
	end

	assign out_valid = v_s2;
	assign out_side  = side_s2;
	assign out_m     = m_s2;

endmodule

[sv/rcpf_div.sv]
`timescale 1ns / 1ps
// Restoring divider pipeline: one quotient bit of m * 2^bits / fade per stage.
module rcpf_div #(
	parameter int GAIN_TABLE_BITS = rcpf_pkg::GAIN_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rcpf_pkg::side_t               in_side,
	input  logic [rcpf_pkg::FADE_W-1:0]   in_m,
	input  logic [rcpf_pkg::FADE_W-1:0]   fade_frames,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rcpf_pkg::side_t               out_side,
	output logic [GAIN_TABLE_BITS-1:0]    out_quo
);
	import rcpf_pkg::*;

	localparam int STAGES = GAIN_TABLE_BITS;

	logic [STAGES-1:0]  v_a;
	logic [STAGES-1:0]  en_a;
	side_t              side_a [STAGES];
	logic [FADE_W-1:0]  rem_a  [STAGES];
	logic [STAGES-1:0]  quo_a  [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic               v_prev;
		side_t              side_prev;
		logic [FADE_W-1:0]  rem_prev;
		logic [STAGES-1:0]  quo_prev;
		logic               en_next;
		logic [FADE_W:0]    dbl;
		logic               fit;
		logic               v_s;
		side_t              side_s;
		logic [FADE_W-1:0]  rem_s;
		logic [STAGES-1:0]  quo_s;

		if (i == 0) begin : g_first
			assign v_prev    = in_valid;
			assign side_prev = in_side;
			assign rem_prev  = in_m;
			assign quo_prev  = '0;
		end else begin : g_next
			assign v_prev    = v_a[i-1];
			assign side_prev = side_a[i-1];
			assign rem_prev  = rem_a[i-1];
			assign quo_prev  = quo_a[i-1];
		end

		if (i == STAGES - 1) begin : g_last
			assign en_next = out_ready;
		end else begin : g_mid
			assign en_next = en_a[i+1];
		end

		assign en_a[i] = !v_s || en_next;

		// Double the remainder and subtract the divisor where it fits
		assign dbl = {rem_prev, 1'b0};
		assign fit = dbl >= {1'b0, fade_frames};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else if (en_a[i]) begin
				v_s <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en_a[i]) begin
				side_s <= side_prev;
				rem_s  <= fit ? FADE_W'(dbl - {1'b0, fade_frames}) : dbl[FADE_W-1:0];
				quo_s  <= {quo_prev[STAGES-2:0], fit};
			end
		end

		assign v_a[i]    = v_s;
		assign side_a[i] = side_s;
		assign rem_a[i]  = rem_s;
		assign quo_a[i]  = quo_s;
	end

	assign in_ready  = en_a[0];
	assign out_valid = v_a[STAGES-1];
	assign out_side  = side_a[STAGES-1];
	assign out_quo   = quo_a[STAGES-1];

endmodule

[sv/rcpf_gain.sv]
`timescale 1ns / 1ps
// Gain stages: fold the phase onto the quarter-wave table, read it, form the raised cosine.
module rcpf_gain #(
	parameter int GAIN_TABLE_BITS = rcpf_pkg::GAIN_TABLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS  = rcpf_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rcpf_pkg::side_t               in_side,
	input  logic [GAIN_TABLE_BITS-1:0]    in_quo,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rcpf_pkg::side_t               out_side,
	output logic [GAIN_FRAC_BITS:0]       out_gain
);
	import rcpf_pkg::*;

	localparam int HALF   = 1 << (GAIN_TABLE_BITS - 1);
	localparam int SINE_W = GAIN_FRAC_BITS + 1;
	localparam logic [GAIN_TABLE_BITS-1:0] HALF_IDX = {1'b1, {(GAIN_TABLE_BITS - 1){1'b0}}};
	localparam logic [SINE_W:0] ONE = {2'b01, {GAIN_FRAC_BITS{1'b0}}};

	logic [SINE_W-1:0]           sine_rom [HALF + 1];
	logic                        v_s1;
	logic                        v_s2;
	logic                        v_s3;
	logic                        en_s1;
	logic                        en_s2;
	logic                        en_s3;
	side_t                       side_s1;
	side_t                       side_s2;
	side_t                       side_s3;
	logic [GAIN_TABLE_BITS-1:0]  idx_s1;
	logic                        upper_s1;
	logic                        upper_s2;
	logic [SINE_W-1:0]           sine_s2;
	logic [GAIN_FRAC_BITS:0]     gain_s3;
	logic                        upper;
	logic [SINE_W:0]             sum;

	// Quarter-wave sine table, built at elaboration
	for (genvar j = 0; j <= HALF; j++) begin : g_rom
		localparam logic [63:0] SINE_VAL = sine_entry(j, GAIN_TABLE_BITS, GAIN_FRAC_BITS);
		assign sine_rom[j] = SINE_VAL[SINE_W-1:0];
	end

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Upper half of the ramp adds the sine, lower half subtracts the mirrored entry
	assign upper = in_quo > HALF_IDX;
	assign sum   = upper_s2 ? (ONE + {1'b0, sine_s2}) : (ONE - {1'b0, sine_s2});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1  <= in_side;
			upper_s1 <= upper;
			idx_s1   <= upper ? (in_quo - HALF_IDX) : (HALF_IDX - in_quo);
		end
		if (en_s2) begin
			side_s2  <= side_s1;
			upper_s2 <= upper_s1;
			sine_s2  <= sine_rom[idx_s1];
		end
		if (en_s3) begin
			side_s3 <= side_s2;
			gain_s3 <= side_s2.zero ? '0 : sum[SINE_W:1];
		end
	end

	assign out_valid = v_s3;
	assign out_side  = side_s3;
	assign out_gain  = gain_s3;

endmodule

[sv/rcpf_scale.sv]
`timescale 1ns / 1ps
// Scale stages: multiply both sample magnitudes by the gain and restore the sign.
module rcpf_scale #(
	parameter int GAIN_FRAC_BITS = rcpf_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rcpf_pkg::side_t             in_side,
	input  logic [GAIN_FRAC_BITS:0]     in_gain,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rcpf_pkg::out_item_t         out_item
);
	import rcpf_pkg::*;

	localparam int PROD_W = SAMPLE_W + GAIN_FRAC_BITS + 1;

	logic                 v_s1;
	logic                 v_s2;
	logic                 en_s1;
	logic                 en_s2;
	side_t                side_s1;
	logic [PROD_W-1:0]    prod_l_s1;
	logic [PROD_W-1:0]    prod_r_s1;
	out_item_t            item_s2;
	logic [SAMPLE_W-1:0]  mag_l;
	logic [SAMPLE_W-1:0]  mag_r;
	logic [SAMPLE_W-1:0]  scaled_l;
	logic [SAMPLE_W-1:0]  scaled_r;
	logic [SAMPLE_W-1:0]  res_l;
	logic [SAMPLE_W-1:0]  res_r;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Magnitudes; the most negative sample maps to its unsigned magnitude
	assign mag_l = in_side.left[SAMPLE_W-1]  ? (~in_side.left + 1'b1)  : in_side.left;
	assign mag_r = in_side.right[SAMPLE_W-1] ? (~in_side.right + 1'b1) : in_side.right;

	// Drop the fraction bits, then negate back where the sample was negative
	assign scaled_l = prod_l_s1[GAIN_FRAC_BITS +: SAMPLE_W];
	assign scaled_r = prod_r_s1[GAIN_FRAC_BITS +: SAMPLE_W];
	assign res_l    = side_s1.left[SAMPLE_W-1]  ? (~scaled_l + 1'b1) : scaled_l;
	assign res_r    = side_s1.right[SAMPLE_W-1] ? (~scaled_r + 1'b1) : scaled_r;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1   <= in_side;
			prod_l_s1 <= PROD_W'(mag_l) * PROD_W'(in_gain);
			prod_r_s1 <= PROD_W'(mag_r) * PROD_W'(in_gain);
		end
		if (en_s2) begin
			item_s2.left_out  <= side_s1.pass ? side_s1.left  : $signed(res_l);
			item_s2.right_out <= side_s1.pass ? side_s1.right : $signed(res_r);
			item_s2.last_out  <= side_s1.last;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

[sv/raised_cosine_program_fade.sv]
`timescale 1ns / 1ps
// Top level of the raised-cosine program fade: registers, pipeline sections, checks.
//
//  channel  direction  handshake                    payload
//  frame    in         frame_valid / frame_ready    frame  (in_item_t)
//  result   out        result_valid / result_ready  result (out_item_t)
//  cfg      in         cfg_we                       cfg_index, cfg_wdata
//
// One item enters per cycle while the pipeline is not stalled; most of the stages belong to
// the restoring divider, which settles one quotient bit per stage.
// Reset clears every stage valid bit and loads the register defaults.
// Each stage holds while full and its successor is blocked, so empty stages close up
// under a stall and a waiting result stops new items only once every stage is full.
module raised_cosine_program_fade #(
	parameter int GAIN_TABLE_BITS = rcpf_pkg::GAIN_TABLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS  = rcpf_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        frame_valid,
	output logic                        frame_ready,
	input  rcpf_pkg::in_item_t          frame,
	output logic                        result_valid,
	input  logic                        result_ready,
	output rcpf_pkg::out_item_t         result,
	input  logic                        cfg_we,
	input  rcpf_pkg::cfg_reg_t          cfg_index,
	input  logic [rcpf_pkg::CFG_W-1:0]  cfg_wdata
);
	import rcpf_pkg::*;

	localparam logic [GAIN_FRAC_BITS:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

	logic [FRAME_W-1:0]          total_q;
	logic [FADE_W-1:0]           fade_q;
	logic                        front_valid;
	logic                        front_ready;
	side_t                       front_side;
	logic [FADE_W-1:0]           front_m;
	logic                        div_valid;
	logic                        div_ready;
	side_t                       div_side;
	logic [GAIN_TABLE_BITS-1:0]  div_quo;
	logic                        gain_valid;
	logic                        gain_ready;
	side_t                       gain_side;
	logic [GAIN_FRAC_BITS:0]     gain;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
			fade_q  <= FADE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOTAL: total_q <= cfg_wdata[FRAME_W-1:0];
				REG_FADE:  fade_q  <= cfg_wdata[FADE_W-1:0];
				default:   total_q <= total_q;
			endcase
		end
	end

	rcpf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (frame_valid),
		.in_ready     (frame_ready),
		.in_item      (frame),
		.total_frames (total_q),
		.fade_frames  (fade_q),
		.out_valid    (front_valid),
		.out_ready    (front_ready),
		.out_side     (front_side),
		.out_m        (front_m)
	);

	rcpf_div #(
		.GAIN_TABLE_BITS (GAIN_TABLE_BITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (front_valid),
		.in_ready    (front_ready),
		.in_side     (front_side),
		.in_m        (front_m),
		.fade_frames (fade_q),
		.out_valid   (div_valid),
		.out_ready   (div_ready),
		.out_side    (div_side),
		.out_quo     (div_quo)
	);

	rcpf_gain #(
		.GAIN_TABLE_BITS (GAIN_TABLE_BITS),
		.GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_side   (div_side),
		.in_quo    (div_quo),
		.out_valid (gain_valid),
		.out_ready (gain_ready),
		.out_side  (gain_side),
		.out_gain  (gain)
	);

	rcpf_scale #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (gain_valid),
		.in_ready  (gain_ready),
		.in_side   (gain_side),
		.in_gain   (gain),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_item  (result)
	);

	// Back-pressure at the input only when every stage is full and the output is blocked
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_ready |-> result_valid && !result_ready)
		else $error("input stalled while the pipeline has room");

	// An endless program always passes frames through
	a_endless_passes: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && (total_q == '0) |-> front_side.pass)
		else $error("endless program item not marked for pass-through");

	// The shaped gain never exceeds unity
	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		gain_valid |-> gain <= GAIN_ONE)
		else $error("fade gain above unity");

	// Frames at or past the program edges carry a zero gain
	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		gain_valid && gain_side.zero |-> gain == '0)
		else $error("silenced item carries a non-zero gain");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the raised-cosine program fade: directed table, random phases, scoreboard.
module testbench;
	import rcpf_pkg::*;

	localparam int TBITS     = GAIN_TABLE_BITS_DEF;
	localparam int QBITS     = GAIN_FRAC_BITS_DEF;
	localparam int HALF      = 1 << (TBITS - 1);
	localparam int DRAIN     = GAIN_TABLE_BITS_DEF + 7 + 13;
	localparam int PHASES    = 10;
	localparam int PER_PHASE = 165;
	localparam int ROWS      = 24;

	// One directed row: the setting it runs under, the frame, and a hand-typed answer if any
	typedef struct packed {
		logic [FRAME_W-1:0]         total;
		logic [FADE_W-1:0]          fade;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [FRAME_W-1:0]         index;
		logic                       last;
		logic                       typed;
		logic signed [SAMPLE_W-1:0] want_left;
		logic signed [SAMPLE_W-1:0] want_right;
	} directed_row_t;

	directed_row_t directed_rows [0:ROWS-1] = '{
		// endless program at the reset setting: everything passes
		'{0, 88200, 32767, -32768, 0, 0, 1, 32767, -32768},
		'{0, 88200, -32768, 32767, 31'h7FFFFFFF, 1, 1, -32768, 32767},
		'{0, 88200, 0, -1, 88199, 0, 1, 0, -1},
		// short program: silent edges, pass in the middle, ramps in between
		'{1000, 100, 12345, -12345, 0, 1, 1, 0, 0},
		'{1000, 100, 32767, -32768, 500, 0, 1, 32767, -32768},
		'{1000, 100, -32768, 32767, 1000, 1, 1, 0, 0},
		'{1000, 100, 1, -1, 1001, 0, 1, 0, 0},
		'{1000, 100, 32767, -32768, 31'h7FFFFFFF, 1, 1, 0, 0},
		'{1000, 100, 32767, -32768, 1, 0, 0, 0, 0},
		'{1000, 100, 32767, -32768, 50, 1, 0, 0, 0},
		'{1000, 100, -32768, 32767, 99, 0, 0, 0, 0},
		'{1000, 100, -32768, 32767, 100, 1, 1, -32768, 32767},
		'{1000, 100, 32767, -1, 900, 0, 1, 32767, -1},
		'{1000, 100, -32768, 32767, 901, 1, 0, 0, 0},
		'{1000, 100, 32767, -32768, 999, 0, 0, 0, 0},
		// one-frame program and one-frame fade
		'{1, 1, 32767, -32768, 0, 1, 1, 0, 0},
		'{1, 1, -32768, 32767, 1, 0, 1, 0, 0},
		'{1, 1, 32767, 32767, 2, 1, 1, 0, 0},
		// longest program with the longest fade
		'{31'h7FFFFFFF, 20'hFFFFF, -32768, 32767, 1048575, 0, 1, -32768, 32767},
		'{31'h7FFFFFFF, 20'hFFFFF, 32767, -32768, 1048574, 1, 0, 0, 0},
		'{31'h7FFFFFFF, 20'hFFFFF, -32768, 32767, 31'h7FFFFFFE, 0, 0, 0, 0},
		// zero fade length: pass inside the program, silence past its end
		'{600, 0, 32767, -32768, 0, 1, 1, 32767, -32768},
		'{600, 0, -32768, 32767, 600, 0, 1, -32768, 32767},
		'{600, 0, 32767, -32768, 601, 1, 1, 0, 0}
	};

	logic      clk;
	logic      arst_n;
	logic      frame_valid;
	logic      frame_ready;
	in_item_t  frame;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;
	logic      cfg_we;
	cfg_reg_t  cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	// Shadow registers and the quarter-wave table of the gain predictor
	logic [FRAME_W-1:0] total_cfg;
	logic [FADE_W-1:0]  fade_cfg;
	longint unsigned    sine_lut [0:HALF];

	out_item_t fade_expect [$];
	bit        failed = 1'b0;
	int        sink_stall = 0;
	int        sink_calm = 0;
	int        source_calm;

	raised_cosine_program_fade dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sine over a quarter wave in Q30 by a Horner-form series, rounded to the gain format
	function automatic longint unsigned quarter_sine(int j);
		longint unsigned one;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned v;
		longint unsigned denom [0:5];
		one = 64'd1 << 30;
		denom = '{156, 110, 72, 42, 20, 6};
		x = (64'd1686629713 * longint'(j)) / HALF;
		x2 = (x * x) >> 30;
		t = one;
		for (int i = 0; i < 6; i++)
			t = one - ((x2 * t) >> 30) / denom[i];
		v = (x * t) >> 30;
		return (v + (64'd1 << (29 - QBITS))) >> (30 - QBITS);
	endfunction

	// Raised-cosine gain at phase step k of the full half-wave
	function automatic longint unsigned fade_gain_q(longint unsigned k);
		longint unsigned one;
		one = 64'd1 << QBITS;
		if (k <= HALF)
			return (one - sine_lut[HALF - k]) >> 1;
		return (one + sine_lut[(k - HALF) & (2 * HALF - 1)]) >> 1;
	endfunction

	// Scale one sample, truncating toward zero
	function automatic logic signed [SAMPLE_W-1:0] scale_by_gain(logic signed [SAMPLE_W-1:0] s,
			longint unsigned g);
		longint x;
		longint unsigned mag;
		x = s;
		mag = (x < 0) ? -x : x;
		mag = (mag * g) >> QBITS;
		return (x < 0) ? SAMPLE_W'(-longint'(mag)) : SAMPLE_W'(mag);
	endfunction

	// Expected output frame under the current setting
	function automatic out_item_t faded_frame(in_item_t f);
		out_item_t r;
		longint pos;
		longint tail;
		longint m;
		longint unsigned g;
		pos = f.frame_index;
		tail = longint'(total_cfg) - pos;
		m = (pos < tail) ? pos : tail;
		r.last_out = f.last_frame;
		if (total_cfg == 0 || m >= longint'(fade_cfg)) begin
			r.left_out = f.left_in;
			r.right_out = f.right_in;
			return r;
		end
		g = 0;
		if (m > 0)
			g = fade_gain_q((unsigned'(m) << TBITS) / fade_cfg);
		r.left_out = scale_by_gain(f.left_in, g);
		r.right_out = scale_by_gain(f.right_in, g);
		return r;
	endfunction

	// Gap length: mostly none, often short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(19))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Frame position biased toward the fade-in, the fade-out and the end of the program
	function automatic logic [FRAME_W-1:0] pick_index(longint t, longint f);
		longint lo;
		longint hi;
		int r;
		r = $urandom_range(99);
		if (t == 0 || r >= 90)
			return FRAME_W'($urandom);
		if (r < 35) begin
			lo = 0;
			hi = f + 2;
		end else if (r < 70) begin
			lo = t - f - 2;
			hi = t + 2;
		end else if (r < 80) begin
			lo = 0;
			hi = t;
		end else begin
			lo = t;
			hi = t + f + 50;
		end
		if (lo < 0)
			lo = 0;
		if (hi > 64'h7FFFFFFF)
			hi = 64'h7FFFFFFF;
		return FRAME_W'(lo + longint'($urandom) % (hi - lo + 1));
	endfunction

	// Offer one frame after an optional gap, hold until taken, then queue its answer
	task automatic deliver_frame(in_item_t f, bit typed, out_item_t want);
		int gap;
		gap = (source_calm > 0) ? 0 : pick_gap();
		if (source_calm > 0)
			source_calm--;
		else if ($urandom_range(199) == 0)
			source_calm = $urandom_range(150, 40);
		@(negedge clk);
		if (gap > 0) begin
			frame_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_valid = 1'b1;
		frame = f;
		do @(posedge clk); while (!frame_ready);
		fade_expect.push_back(typed ? want : faded_frame(f));
	endtask

	// Drain the pipe, then load both registers
	task automatic program_fade(logic [FRAME_W-1:0] total, logic [FADE_W-1:0] fade);
		@(negedge clk);
		frame_valid = 1'b0;
		while (fade_expect.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = REG_TOTAL;
		cfg_wdata = total;
		@(negedge clk);
		cfg_index = REG_FADE;
		cfg_wdata = CFG_W'(fade);
		// junk above the fade field must be dropped
		if ($urandom_range(1))
			cfg_wdata[CFG_W-1:FADE_W] = (CFG_W - FADE_W)'($urandom);
		@(negedge clk);
		cfg_we = 1'b0;
		total_cfg = total;
		fade_cfg = fade;
	endtask

	// Stall the result side in random bursts, with calm stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready = 1'b0;
		end else if (sink_stall > 0) begin
			result_ready = 1'b0;
			sink_stall--;
		end else begin
			result_ready = 1'b1;
			if (sink_calm > 0)
				sink_calm--;
			else if ($urandom_range(299) == 0)
				sink_calm = $urandom_range(200, 50);
			else if ($urandom_range(3) == 0)
				sink_stall = pick_gap();
		end
	end

	// Compare each delivered frame with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (fade_expect.size() == 0) begin
				$error("result with nothing expected: left %0d right %0d last %0b",
					result.left_out, result.right_out, result.last_out);
				failed = 1'b1;
			end else begin
				want = fade_expect.pop_front();
				if (result.left_out !== want.left_out) begin
					$error("left_out: expected %0d, got %0d", want.left_out, result.left_out);
					failed = 1'b1;
				end
				if (result.right_out !== want.right_out) begin
					$error("right_out: expected %0d, got %0d", want.right_out, result.right_out);
					failed = 1'b1;
				end
				if (result.last_out !== want.last_out) begin
					$error("last_out: expected %0b, got %0b", want.last_out, result.last_out);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("raised_cosine_program_fade verification failed");
		$finish;
	end

	initial begin
		in_item_t  f;
		out_item_t want;
		longint    t;
		longint    fd;
		arst_n = 1'b0;
		frame_valid = 1'b0;
		frame = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TOTAL;
		cfg_wdata = '0;
		source_calm = 0;
		total_cfg = TOTAL_RESET;
		fade_cfg = FADE_RESET;
		for (int j = 0; j <= HALF; j++)
			sine_lut[j] = quarter_sine(j);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows, reprogramming whenever a row asks for a new setting
		for (int i = 0; i < ROWS; i++) begin
			if (directed_rows[i].total != total_cfg || directed_rows[i].fade != fade_cfg)
				program_fade(directed_rows[i].total, directed_rows[i].fade);
			f.left_in = directed_rows[i].left;
			f.right_in = directed_rows[i].right;
			f.frame_index = directed_rows[i].index;
			f.last_frame = directed_rows[i].last;
			want.left_out = directed_rows[i].want_left;
			want.right_out = directed_rows[i].want_right;
			want.last_out = directed_rows[i].last;
			deliver_frame(f, directed_rows[i].typed, want);
		end

		// Random phases, each under its own program and fade length
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin t = 1000; fd = 100; end
				1: begin t = 64'h7FFFFFFF; fd = 20'hFFFFF; end
				2: begin t = 1; fd = 1; end
				3: begin t = 64'h7FFFFFFF; fd = 1; end
				4: begin t = 5000; fd = 0; end
				5: begin t = 300; fd = 20'hFFFFF; end
				6: begin t = 20000; fd = 4096; end
				7: begin
					t = $urandom_range(1 << 20, 2);
					fd = $urandom_range(t > 20'hFFFFF ? 20'hFFFFF : t, 1);
				end
				8: begin t = $urandom & 32'h7FFFFFFF; fd = $urandom & 32'hFFFFF; end
				default: begin t = 0; fd = 777; end
			endcase
			program_fade(FRAME_W'(t), FADE_W'(fd));
			for (int n = 0; n < PER_PHASE; n++) begin
				f.left_in = pick_sample();
				f.right_in = pick_sample();
				f.frame_index = pick_index(t, fd);
				f.last_frame = 1'($urandom_range(1));
				deliver_frame(f, 1'b0, want);
			end
		end

		// Let everything drain, then a short quiet tail for strays
		@(negedge clk);
		frame_valid = 1'b0;
		while (fade_expect.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (!failed)
			$display("raised_cosine_program_fade verification clean");
		else
			$display("raised_cosine_program_fade verification failed");
		$finish;
	end

endmodule
